// ===== rtl/core/strmm_pkg.sv =====
package strmm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int COUNT_W      = IDX_W + 1;
    localparam int LEVELS       = IDX_W + 1;
    localparam int LVL_W        = $clog2(LEVELS);
    localparam int ADDR_W       = LVL_W + IDX_W;
    localparam int TABLE_DEPTH  = LEVELS * MAX_ELEMENTS;

    // slave tdata layout: value, query_start, query_end, zero pad
    localparam int QS_LSB       = VALUE_BITS;
    localparam int QE_LSB       = VALUE_BITS + IDX_W;
    localparam int S_TDATA_W    = ((VALUE_BITS + 2 * IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;

    // position of the highest set bit, 0 for zero
    function automatic logic [LVL_W-1:0] msb_pos(input logic [IDX_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int b = 0; b < IDX_W; b++) begin
            if (v[b]) begin
                r = LVL_W'(b);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/strmm_pick.sv =====
module strmm_pick
    import strmm_pkg::*;
(
    input  t_value i_a,
    input  t_value i_b,
    input  logic   i_select_max,
    output t_value o_y
);

    logic w_a_ge_b;
    logic w_a_le_b;

    assign w_a_ge_b = ($signed(i_a) >= $signed(i_b));
    assign w_a_le_b = ($signed(i_a) <= $signed(i_b));

    assign o_y = i_select_max ? (w_a_ge_b ? i_a : i_b)
                              : (w_a_le_b ? i_a : i_b);

endmodule

// ===== rtl/core/sparse_table_range_min_max_core.sv =====
// chan | dir | handshake             | payload (tdata / tuser / tlast)
// s    | in  | i_s_tvalid/o_s_tready | value, query_start, query_end / opcode / is_last
// m    | out | o_m_tvalid/i_m_tready | selected / range_valid / -
// cfg  | in  | i_cfg_we              | i_cfg_wdata: select_max
//
// A load request is written to level 0 in its accept cycle while there is room. A load
// with tlast then builds the levels with the shared min/max unit: each built entry reads
// its pair, then writes, and each level starts with a check state.
// A query issues both table reads in the accept cycle; the pick follows in S_Q_PICK.
// A query waits in its pick state while the output register is still held by the sink.
// Reset is synchronous; the table memory is not cleared and only holds data once loaded.
module sparse_table_range_min_max_core
    import strmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [31:0] value, [41:32] query_start,
                                              // [51:42] query_end, rest zero
    input  logic                 i_s_tuser,   // [0] opcode
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [31:0] selected
    output logic                 o_m_tuser    // [0] range_valid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_B_CHK  = 3'd1;
    localparam logic [2:0] S_B_RD   = 3'd2;
    localparam logic [2:0] S_B_WR   = 3'd3;
    localparam logic [2:0] S_Q_PICK = 3'd4;

    // control state
    logic [2:0]         r_state,     n_state;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic               r_built,     n_built;
    logic               r_select_max;
    logic [LVL_W-1:0]   r_k,         n_k;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic [COUNT_W-1:0] r_limit,     n_limit;
    logic               r_q_valid,   n_q_valid;
    logic               r_out_valid, n_out_valid;
    t_value             r_out_data,  n_out_data;
    logic               r_out_flag,  n_out_flag;

    // table memory, level k entry i at {k, i}
    t_value             mem [0:TABLE_DEPTH-1];
    t_value             r_rd_a;
    t_value             r_rd_b;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_value             w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr_a;
    logic [ADDR_W-1:0]  w_raddr_b;

    // shared compare/select unit
    t_value             w_pick;

    // input decode
    logic               w_accept;
    t_value             w_value;
    logic [IDX_W-1:0]   w_q_s;
    logic [IDX_W-1:0]   w_q_e;
    logic [IDX_W-1:0]   w_q_diff;
    logic [LVL_W-1:0]   w_q_ex;
    logic [IDX_W-1:0]   w_q_mask;
    logic [IDX_W-1:0]   w_q_idx_b;
    logic               w_q_ok;
    logic [COUNT_W-1:0] w_base;
    logic               w_room;
    logic [COUNT_W:0]   w_span;
    logic [IDX_W-1:0]   w_half;
    logic               w_out_free;

    strmm_pick u_pick (
        .i_a          (r_rd_a),
        .i_b          (r_rd_b),
        .i_select_max (r_select_max),
        .o_y          (w_pick)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_value = i_s_tdata[VALUE_BITS-1:0];
    assign w_q_s   = i_s_tdata[QS_LSB +: IDX_W];
    assign w_q_e   = i_s_tdata[QE_LSB +: IDX_W];

    // two windows of 2^ex, ex = floor(log2(end - start)); a single element reads itself twice
    assign w_q_diff  = w_q_e - w_q_s;
    assign w_q_ex    = msb_pos(w_q_diff);
    assign w_q_mask  = IDX_W'((IDX_W'(1) << w_q_ex) - IDX_W'(1));
    assign w_q_idx_b = w_q_e - w_q_mask;
    assign w_q_ok    = r_built && (w_q_s <= w_q_e) && ({1'b0, w_q_e} < r_count);

    // a load after a finished build starts a fresh table
    assign w_base = r_built ? '0 : r_count;
    assign w_room = (w_base < COUNT_W'(MAX_ELEMENTS));

    assign w_span = (COUNT_W + 1)'(2) << r_k;
    assign w_half = IDX_W'(1) << r_k;

    assign w_out_free = !r_out_valid || i_m_tready;

    // memory ports
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = {LVL_W'(0), w_base[IDX_W-1:0]};
        w_wdata   = w_value;
        w_re      = 1'b0;
        w_raddr_a = {w_q_ex, w_q_s};
        w_raddr_b = {w_q_ex, w_q_idx_b};
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_s_tuser == OP_LOAD)) begin
                    w_we = w_room;
                end
                if (w_accept && (i_s_tuser == OP_QUERY)) begin
                    w_re = 1'b1;
                end
            end
            S_B_RD: begin
                w_re      = 1'b1;
                w_raddr_a = {r_k, r_idx};
                w_raddr_b = {r_k, r_idx + w_half};
            end
            S_B_WR: begin
                w_we    = 1'b1;
                w_waddr = {LVL_W'(r_k + 1'b1), r_idx};
                w_wdata = w_pick;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_a <= mem[w_raddr_a];
            r_rd_b <= mem[w_raddr_b];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_built     = r_built;
        n_k         = r_k;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_q_valid   = r_q_valid;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_flag  = r_out_flag;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == OP_LOAD) begin
                        n_built = 1'b0;
                        n_count = w_room ? (w_base + 1'b1) : w_base;
                        if (i_s_tlast) begin
                            n_k     = '0;
                            n_state = S_B_CHK;
                        end
                    end else begin
                        n_q_valid = w_q_ok;
                        n_state   = S_Q_PICK;
                    end
                end
            end
            S_B_CHK: begin
                // level k+1 exists only if a window of 2^(k+1) fits
                if (w_span <= {1'b0, r_count}) begin
                    n_limit = COUNT_W'({1'b0, r_count} - w_span);
                    n_idx   = '0;
                    n_state = S_B_RD;
                end else begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_B_RD: begin
                n_state = S_B_WR;
            end
            S_B_WR: begin
                if ({1'b0, r_idx} == r_limit) begin
                    n_k     = LVL_W'(r_k + 1'b1);
                    n_state = S_B_CHK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_B_RD;
                end
            end
            S_Q_PICK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_q_valid ? w_pick : '0;
                    n_out_flag  = r_q_valid;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_built      <= 1'b0;
            r_select_max <= 1'b0;
            r_k          <= '0;
            r_idx        <= '0;
            r_limit      <= '0;
            r_q_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_built     <= n_built;
            r_k         <= n_k;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
            r_q_valid   <= n_q_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_select_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_flag <= n_out_flag;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_data);
    assign o_m_tuser  = r_out_flag;

`ifndef SYNTHESIS
    a_out_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_Q_PICK))
        else $error("result appeared without a query pick");

    a_build_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_CHK) |-> (r_count != '0))
        else $error("build started on an empty table");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("invalid range returned nonzero data");

    a_build_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_RD) |-> (({1'b0, r_idx} + {1'b0, w_half}) < r_count))
        else $error("build read past the loaded elements");
`endif

endmodule
